// File: hw/rtl/dhf_pkg.sv
// ---------------------------------------------------------------------------
// dhf_pkg: shared types and constants for the depth hole fill block
// Sample widths, window geometry, register indexes and the sequencer states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dhf_pkg;

  localparam int PIX_W = 16;   // Q8.8 depth sample
  localparam int WIN   = 5;    // window cells per side
  localparam int LINES = 4;    // line stores
  localparam int YW    = 13;   // row counter, holds frame_height + 1
  localparam int SUM_W = 21;   // 25 * 65535 fits
  localparam int CNT_W = 5;    // up to 25 valid samples

  localparam logic [1:0] CFG_FRAME_WIDTH     = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT    = 2'd1;
  localparam logic [1:0] CFG_VALID_THRESHOLD = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROWSUM,
    ST_TOTAL,
    ST_DIVIDE,
    ST_FINISH
  } dhf_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/dhf_line_buf.sv
// ---------------------------------------------------------------------------
// dhf_line_buf: four line stores
// All lines read at one column, one line written at that column (read-first).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhf_line_buf
  import dhf_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] addr,
  input  wire logic [1:0]                   wr_line,
  input  wire logic [PIX_W-1:0]             wr_data,
  output logic      [LINES-1:0][PIX_W-1:0]  rd_data
);

  for (genvar l = 0; l < LINES; l++) begin : g_line
    logic [PIX_W-1:0] mem [MAX_WIDTH];

    always_ff @(posedge clk) begin
      if (rd_en) begin
        rd_data[l] <= mem[addr];
      end
      if (wr_en && (wr_line == 2'(l))) begin
        mem[addr] <= wr_data;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dhf_cell.sv
// ---------------------------------------------------------------------------
// dhf_cell: one window cell
// Holds one window sample; takes its right neighbor's on shift.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhf_cell
  import dhf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             shift,
  input  wire logic [PIX_W-1:0] in_value,
  output logic      [PIX_W-1:0] value
);

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (shift) begin
      value <= in_value;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dhf_divider.sv
// ---------------------------------------------------------------------------
// dhf_divider: restoring divider, one quotient bit per cycle
// Window sum over valid count; done pulses when the last quotient bit is registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhf_divider
  import dhf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic      [SUM_W-1:0] quotient,
  output logic                  done
);

  localparam int IW = $clog2(SUM_W + 1);

  logic             busy;
  logic [IW-1:0]    iter;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] dvs;
  logic [CNT_W:0]   trial;
  logic             ge;
  logic [CNT_W:0]   diff;

  assign trial = {rem, quotient[SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= busy && (iter == IW'(1));
      if (start) begin
        busy <= 1'b1;
        iter <= IW'(SUM_W);
      end else if (busy) begin
        iter <= iter - IW'(1);
        if (iter == IW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[SUM_W-2:0], ge};
      rem      <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/depth_hole_fill_box_mean_core.sv
// ---------------------------------------------------------------------------
// depth_hole_fill_box_mean_core: masked box-mean hole filler for depth
// Replaces each pixel by the mean of the valid samples in its window.
// ---------------------------------------------------------------------------
// Input (in_valid / in_stall / pixel_value): depth samples in raster order
//   over a padded frame of (frame_height+2) rows of (frame_width+2) items;
//   padding items are ignored and count as invalid.
// Output (out_valid / out_stall / filled_value, valid_count, end_of_frame):
//   one item per image pixel, WINDOW_RADIUS rows and columns behind the input.
// Config (cfg_write, cfg_index, cfg_data): frame_width, frame_height,
//   valid_threshold; write only while no item is in flight.
// Timing: one item at a time, in_stall high while it is in flight. After
//   acceptance the result passes window shift, row sums, total and divider
//   start, the divider bits, divider done and output load. Next item accepted
//   the cycle after the load, so no item is taken before the last is through.
// Stall: the result waits in the output register; the next item is accepted
//   meanwhile and holds at the output load until the register frees.
// Reset: counters, window cells, sequencer and out_valid clear; registers go
//   to 640 x 480, threshold 0. Line stores need no clear.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module depth_hole_fill_box_mean_core
  import dhf_pkg::*;
#(
  parameter int MAX_WIDTH     = 2048,
  parameter int WINDOW_RADIUS = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // config
  input  wire logic             cfg_write,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_data,
  // input items
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [PIX_W-1:0] pixel_value,
  // result items
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [PIX_W-1:0] filled_value,
  output logic      [CNT_W-1:0] valid_count,
  output logic                  end_of_frame
);

  localparam int XW  = $clog2(MAX_WIDTH + 2);
  localparam int PW  = ((XW > 12) ? XW : 12) + 1;  // column compare width
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int LO  = (WIN - 1) - 2 * WINDOW_RADIUS;  // first window cell used
  localparam int CTR = (WIN - 1) - WINDOW_RADIUS;      // centre cell
  localparam int RSW = 19;                             // 5 samples per row

  // ---- config registers ----
  logic [11:0] frame_width;
  logic [11:0] frame_height;
  logic [15:0] valid_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= 12'd640;
      frame_height    <= 12'd480;
      valid_threshold <= 16'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:     frame_width     <= cfg_data[11:0];
        CFG_FRAME_HEIGHT:    frame_height    <= cfg_data[11:0];
        CFG_VALID_THRESHOLD: valid_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- sequencer ----
  dhf_state_t state, state_next;
  logic       accept;
  logic       shift_en;
  logic       div_start;
  logic       div_done;
  logic       out_free;
  logic       finish_fire;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_ROWSUM;
      ST_ROWSUM: state_next = ST_TOTAL;
      ST_TOTAL:  state_next = ST_DIVIDE;
      ST_DIVIDE: if (div_done) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = (state != ST_IDLE);
    shift_en    = (state == ST_LOAD);
    div_start   = (state == ST_TOTAL);
    finish_fire = (state == ST_FINISH) && out_free;
  end

  // ---- position in the padded frame ----
  logic [XW-1:0] col_pos;
  logic [YW-1:0] row_pos;
  logic [PW-1:0] w_eff;
  logic [PW-1:0] x_ext;
  logic [YW-1:0] h_ext;
  logic [PW-1:0] x_inc;
  logic [YW-1:0] y_inc;

  assign w_eff = (PW'(frame_width) > PW'(MAX_WIDTH)) ? PW'(MAX_WIDTH) : PW'(frame_width);
  assign x_ext = PW'(col_pos);
  assign h_ext = YW'(frame_height);
  assign x_inc = x_ext + PW'(1);
  assign y_inc = row_pos + YW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      if (x_inc >= w_eff + PW'(2)) begin
        col_pos <= '0;
        row_pos <= (y_inc >= h_ext + YW'(2)) ? '0 : y_inc;
      end else begin
        col_pos <= x_inc[XW-1:0];
        if (row_pos >= h_ext + YW'(2)) begin
          row_pos <= '0;
        end
      end
    end
  end

  // ---- per-item decisions taken at acceptance ----
  logic             col_in;
  logic [PIX_W-1:0] cur;
  logic [WIN-1:0]   row_ok;
  logic [WIN-1:0]   col_ok;
  logic             produce_now;
  logic             eof_now;

  assign col_in = x_ext < w_eff;
  assign cur    = (col_in && (row_pos < h_ext)) ? pixel_value : '0;

  // window row i holds image row y - (WIN-1-i), column j image column
  // x - (WIN-1-j); both clipped to the image as seen by this item
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      row_ok[i] = (row_pos >= YW'(WIN - 1 - i)) && (row_pos < h_ext + YW'(WIN - 1 - i));
      col_ok[i] = (x_ext >= PW'(WIN - 1 - i)) && (x_ext < w_eff + PW'(WIN - 1 - i));
    end
  end

  assign produce_now = (row_pos >= YW'(WINDOW_RADIUS))
                    && (row_pos < h_ext + YW'(WINDOW_RADIUS))
                    && (x_ext >= PW'(WINDOW_RADIUS))
                    && (x_ext < w_eff + PW'(WINDOW_RADIUS));
  assign eof_now = (row_pos == h_ext + YW'(WINDOW_RADIUS - 1))
                && (x_ext == w_eff + PW'(WINDOW_RADIUS - 1));

  logic             s_col_in;
  logic [PIX_W-1:0] s_cur;
  logic [WIN-1:0]   s_row_ok;
  logic [WIN-1:0]   s_col_ok;
  logic             s_produce;
  logic             s_eof;
  logic [1:0]       s_bank;

  always_ff @(posedge clk) begin
    if (accept) begin
      s_col_in  <= col_in;
      s_cur     <= cur;
      s_row_ok  <= row_ok;
      s_col_ok  <= col_ok;
      s_produce <= produce_now;
      s_eof     <= eof_now;
      s_bank    <= row_pos[1:0];
    end
  end

  // ---- line stores ----
  logic [LINES-1:0][PIX_W-1:0] line_q;

  dhf_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (accept && col_in),
    .wr_en   (accept && col_in),
    .addr    (col_pos[AW-1:0]),
    .wr_line (row_pos[1:0]),
    .wr_data (cur),
    .rd_data (line_q)
  );

  // ---- entering window column ----
  logic [PIX_W-1:0] col_val [WIN];

  always_comb begin
    logic [1:0] li;
    for (int i = 0; i < WIN; i++) begin
      li = s_bank + 2'(i);
      if (i == WIN - 1) begin
        col_val[i] = s_cur;
      end else begin
        col_val[i] = s_col_in ? line_q[li] : '0;
      end
    end
  end

  // ---- window: rows of cells shifting left ----
  logic [PIX_W-1:0] win_val [WIN][WIN];

  for (genvar gi = 0; gi < WIN; gi++) begin : g_row
    for (genvar gj = 0; gj < WIN; gj++) begin : g_col
      if (gj == WIN - 1) begin : g_edge
        dhf_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .shift    (shift_en),
          .in_value (col_val[gi]),
          .value    (win_val[gi][gj])
        );
      end else begin : g_inner
        dhf_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .shift    (shift_en),
          .in_value (win_val[gi][gj+1]),
          .value    (win_val[gi][gj])
        );
      end
    end
  end

  // ---- row sums, then window total ----
  // clip and threshold are applied here, against the current item's position
  logic [RSW-1:0]   rs      [WIN];
  logic [2:0]       rc      [WIN];
  logic [RSW-1:0]   row_sum [WIN];
  logic [2:0]       row_cnt [WIN];
  logic [PIX_W-1:0] centre;

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      rs[i] = '0;
      rc[i] = '0;
      for (int j = 0; j < WIN; j++) begin
        if ((i >= LO) && (j >= LO) && s_row_ok[i] && s_col_ok[j]
            && (win_val[i][j] > valid_threshold)) begin
          rs[i] = rs[i] + RSW'(win_val[i][j]);
          rc[i] = rc[i] + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ROWSUM) begin
      for (int i = 0; i < WIN; i++) begin
        row_sum[i] <= rs[i];
        row_cnt[i] <= rc[i];
      end
      centre <= win_val[CTR][CTR];
    end
  end

  logic [SUM_W-1:0] total_sum;
  logic [CNT_W-1:0] total_cnt;
  logic [CNT_W-1:0] cnt_q;

  always_comb begin
    total_sum = '0;
    total_cnt = '0;
    for (int i = 0; i < WIN; i++) begin
      total_sum = total_sum + SUM_W'(row_sum[i]);
      total_cnt = total_cnt + CNT_W'(row_cnt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      cnt_q <= total_cnt;
    end
  end

  // ---- mean ----
  logic [SUM_W-1:0] quotient;

  dhf_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total_sum),
    .divisor  (total_cnt),
    .quotient (quotient),
    .done     (div_done)
  );

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && out_stall) || (finish_fire && s_produce);
    end
  end

  always_ff @(posedge clk) begin
    if (finish_fire && s_produce) begin
      filled_value <= (cnt_q != '0) ? quotient[PIX_W-1:0] : centre;
      valid_count  <= cnt_q;
      end_of_frame <= s_eof;
    end
  end

  // ---- assertions ----
  a_total_to_div: assert property (@(posedge clk) disable iff (rst)
    state == ST_TOTAL |=> state == ST_DIVIDE)
    else $error("sequencer skipped divide");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVIDE)
    else $error("divider done outside divide step");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> valid_count <= CNT_W'(WIN * WIN))
    else $error("valid count out of range");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result loaded outside finish step");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for depth_hole_fill_box_mean_core
// Streams padded depth frames through the block under several frame sizes,
// thresholds and idling patterns. A local hole-fill predictor computes each
// expected window mean, and every result item is checked field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import dhf_pkg::*;

  localparam int MAXW = 2048;

  typedef struct packed {
    logic [PIX_W-1:0] fill;
    logic [CNT_W-1:0] cnt;
    logic             eof;
  } fill_res_t;

  typedef struct {
    logic [15:0] pix;
    bit          typed;
    fill_res_t   res;
  } stim_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_write;
  logic [1:0]       cfg_index;
  logic [15:0]      cfg_data;
  logic             in_valid;
  logic             in_stall;
  logic [PIX_W-1:0] pixel_value;
  logic             out_valid;
  logic             out_stall;
  logic [PIX_W-1:0] filled_value;
  logic [CNT_W-1:0] valid_count;
  logic             end_of_frame;

  depth_hole_fill_box_mean_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .pixel_value(pixel_value),
    .out_valid(out_valid), .out_stall(out_stall), .filled_value(filled_value),
    .valid_count(valid_count), .end_of_frame(end_of_frame)
  );

  // predictor copy of the block state and registers
  int unsigned fw, fh, thr;
  logic [15:0] lstore [4][MAXW];
  logic [15:0] win [5][5];
  int unsigned cpos, rpos;

  fill_res_t   fill_q[$];        // expected results, oldest first
  int          mismatches;
  int          idle_pct, stall_pct;
  bit          hold_go;          // long receiver hold-off request
  bit          drv_typed;        // current item carries a typed expectation
  fill_res_t   drv_res;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // One step of the hole filler over the padded raster.
  function automatic bit fill_step(input logic [15:0] pix, output fill_res_t r);
    int unsigned w, h, x, y, sum, cnt, ry, cx;
    logic [15:0] cur, v, ctr;
    logic [15:0] col [5];
    bit made;
    w = (fw > MAXW) ? MAXW : fw;
    h = fh;
    x = cpos;
    y = rpos;
    made = 1'b0;
    r = '0;
    cur = (x < w && y < h) ? pix : 16'd0;   // padding stored as zero
    for (int i = 0; i < 4; i++) col[i] = (x < w) ? lstore[(y + i) % 4][x] : 16'd0;
    col[4] = cur;
    if (x < w) lstore[y % 4][x] = cur;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 4; j++) win[i][j] = win[i][j+1];
      win[i][4] = col[i];
    end
    // output lags the input by two rows and two columns
    if (y >= 2 && x >= 2 && y - 2 < h && x - 2 < w) begin
      sum = 0;
      cnt = 0;
      ctr = win[2][2];
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 5; j++) begin
          ry = y + i;
          cx = x + j;
          v = win[i][j];
          // clip the window to the image
          if (ry >= 4 && cx >= 4 && ry - 4 < h && cx - 4 < w && v > thr) begin
            sum += v;
            cnt++;
          end
        end
      end
      r.fill = (cnt != 0) ? 16'(sum / cnt) : ctr;
      r.cnt  = CNT_W'(cnt);
      r.eof  = (y - 2 == h - 1) && (x - 2 == w - 1);
      made = 1'b1;
    end
    x++;
    if (x >= w + 2) begin
      x = 0;
      y++;
      if (y >= h + 2) y = 0;
    end else if (y >= h + 2) begin
      y = 0;
    end
    cpos = x;
    rpos = y;
    return made;
  endfunction

  // accepted input items feed the predictor
  always @(posedge clk) begin
    fill_res_t r;
    if (!rst && in_valid && !in_stall) begin
      if (fill_step(pixel_value, r)) fill_q.push_back(drv_typed ? drv_res : r);
    end
  end

  // accepted result items are checked against the oldest expectation
  always @(posedge clk) begin
    fill_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (fill_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: fill=%h cnt=%0d eof=%b",
                   filled_value, valid_count, end_of_frame);
      end else begin
        e = fill_q.pop_front();
        if (e.fill !== filled_value || e.cnt !== valid_count || e.eof !== end_of_frame) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp fill=%h cnt=%0d eof=%b, got fill=%h cnt=%0d eof=%b",
                     e.fill, e.cnt, e.eof, filled_value, valid_count, end_of_frame);
        end
      end
    end
  end

  // receiver stalls: random, or held for a long stretch on request
  always @(negedge clk) begin
    out_stall <= hold_go || ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    forever begin
      wait (hold_go);
      repeat (400) @(negedge clk);
      hold_go = 1'b0;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_FRAME_WIDTH:     fw  = data & 16'hFFF;
      CFG_FRAME_HEIGHT:    fh  = data & 16'hFFF;
      CFG_VALID_THRESHOLD: thr = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(input int w, input int h, input int t, input int mode);
    write_reg(CFG_FRAME_WIDTH, 16'(w));
    write_reg(CFG_FRAME_HEIGHT, 16'(h));
    write_reg(CFG_VALID_THRESHOLD, 16'(t));
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 65; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 65; end
      default: begin idle_pct = 25; stall_pct = 25; end
    endcase
  endtask

  // offer one item and hold it until accepted
  task automatic send_pixel(input logic [15:0] v, input bit typed, input fill_res_t e);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    pixel_value <= v;
    drv_typed   <= typed;
    drv_res     <= e;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // random depth sample: holes at or below the threshold with given odds
  function automatic logic [15:0] depth_sample(input int hole_pct);
    if ($urandom_range(0, 99) < hole_pct) return 16'($urandom_range(0, thr));
    return 16'($urandom_range(thr, 65535));
  endfunction

  task automatic send_frames(input int frames, input int skip);
    int w, h, holes, n;
    w = (fw > MAXW) ? MAXW : fw;
    h = fh;
    n = 0;
    for (int f = 0; f < frames; f++) begin
      holes = $urandom_range(0, 100);
      for (int k = 0; k < (w + 2) * (h + 2); k++) begin
        if (n >= skip) send_pixel(depth_sample(holes), 1'b0, '0);
        n++;
      end
    end
  endtask

  // let everything in flight come out before touching the registers
  task automatic drain;
    wait (fill_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  stim_row_t dir_rows [25];
  int        rand_items;

  initial begin
    cfg_write   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    pixel_value = '0;
    out_stall   = 1'b0;
    drv_typed   = 1'b0;
    drv_res     = '0;
    hold_go     = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    mismatches  = 0;
    fw = 640;
    fh = 480;
    thr = 0;
    cpos = 0;
    rpos = 0;
    for (int i = 0; i < 4; i++) for (int j = 0; j < MAXW; j++) lstore[i][j] = '0;
    for (int i = 0; i < 5; i++) for (int j = 0; j < 5; j++) win[i][j] = '0;

    rst = 1'b1;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed frame, 5x5 image in a 7-wide padded raster, threshold 0x00FF.
    // Rows 0..2 plus the start of row 3; padding columns carry junk values.
    // The first result (pixel 0,0) sees only samples at or below the
    // threshold, so it falls back to its own value with a zero count.
    configure(5, 5, 16'h00FF, 0);
    begin
      logic [15:0] vals [25] = '{
        16'h00FF, 16'h0000, 16'h0010, 16'hFFFF, 16'h8000, 16'hFFFF, 16'hFFFF,
        16'h0001, 16'h00FE, 16'h00FF, 16'h0100, 16'h7FFF, 16'hABCD, 16'h1234,
        16'h0042, 16'h0000, 16'h00FF, 16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF,
        16'h0100, 16'h0000, 16'hFFFF, 16'h00FF};
      for (int i = 0; i < 25; i++) begin
        dir_rows[i].pix   = vals[i];
        dir_rows[i].typed = (i == 16);
        dir_rows[i].res   = '{fill: 16'h00FF, cnt: 5'd0, eof: 1'b0};
      end
    end
    foreach (dir_rows[i]) send_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].res);
    send_frames(1, 25);                  // rest of the directed frame
    @(negedge clk);
    in_valid <= 1'b0;
    drain();

    // random phases over small frames, cycling the idling patterns
    rand_items = 0;
    for (int ph = 0; rand_items < 1800; ph++) begin
      int w, h, t, fr;
      w = $urandom_range(5, 12);
      h = $urandom_range(5, 9);
      case ($urandom_range(0, 3))
        0: t = 0;
        1: t = 65535;
        default: t = $urandom_range(0, 65535);
      endcase
      fr = $urandom_range(1, 2);
      configure(w, h, t, ph % 4);
      if (ph == 4) hold_go = 1'b1;       // sender keeps going, block backs up
      send_frames(fr, 0);
      rand_items += fr * (w + 2) * (h + 2);
      @(negedge clk);
      in_valid <= 1'b0;
      drain();
    end

    // degenerate sizes: the counters run but nothing comes out
    configure(0, 7, 0, 3);
    send_frames(1, 0);
    @(negedge clk);
    in_valid <= 1'b0;
    drain();
    configure(6, 0, 0, 1);
    send_frames(1, 0);
    @(negedge clk);
    in_valid <= 1'b0;
    drain();

    if (mismatches == 0 && fill_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
